// ===== rtl/aavr_pkg.sv =====
// Shared types, fixed-point constants and the CORDIC arctangent table.
package aavr_pkg;

  // Angle path width (Q.30 with headroom for the two pi wrap)
  localparam int ZW = 36;
  // CORDIC x and y width (Q.30)
  localparam int CW = 34;
  // Width of each rounded term before the final sum
  localparam int TW = 60;

  localparam logic signed [ZW-1:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [ZW-1:0] GAIN_Q30    = 36'sd652032874;

  // Vector, axis, dot and cross terms as they travel beside the CORDIC
  typedef struct packed {
    logic [2:0][31:0] v;
    logic [2:0][18:0] k;
    logic [52:0]      dot;
    logic [2:0][51:0] cr;
  } geo_t;

  // atan(2^-i) in Q.30
  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 36'sd843314857;
      1:  a = 36'sd497837829;
      2:  a = 36'sd263043837;
      3:  a = 36'sd133525159;
      4:  a = 36'sd67021687;
      5:  a = 36'sd33543516;
      6:  a = 36'sd16775851;
      7:  a = 36'sd8388437;
      8:  a = 36'sd4194283;
      9:  a = 36'sd2097149;
      10: a = 36'sd1048576;
      11: a = 36'sd524288;
      12: a = 36'sd262144;
      13: a = 36'sd131072;
      14: a = 36'sd65536;
      15: a = 36'sd32768;
      16: a = 36'sd16384;
      17: a = 36'sd8192;
      18: a = 36'sd4096;
      19: a = 36'sd2048;
      20: a = 36'sd1024;
      21: a = 36'sd512;
      22: a = 36'sd256;
      23: a = 36'sd128;
      24: a = 36'sd64;
      25: a = 36'sd32;
      26: a = 36'sd16;
      27: a = 36'sd8;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/axis_angle_vector_rotation.sv =====
// Top level: rotates a vector about a unit axis by an angle (Rodrigues formula).
//
// Input channel: in_valid/in_ready carry vec_x/y/z (Q16.16), axis_x/y/z
// (Q3.16) and turn_angle (radians, Q4.20); one transaction per item.
// Output channel: out_valid/out_ready carry out_x/y/z (Q16.16, saturated)
// and overflow, set when any component was clamped.
// One CORDIC stage per register, beside it the dot and cross products,
// then seven stages of split multiplies, rounding, summation and clamping.
// Throughput is one item per cycle while results are taken; the whole
// pipeline moves on one enable, so in_ready is high whenever the output
// register is empty or is being taken.
// When the receiver stalls with a result waiting, every stage holds and
// in_ready drops; nothing is lost or repeated.
// Reset clears the per-stage valid bits only; the pipeline holds no state
// between items.
module axis_angle_vector_rotation #(
  parameter int CORDIC_STAGES = 20,
  parameter int FRAC_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [18:0] axis_x,
  input  logic signed [18:0] axis_y,
  input  logic signed [18:0] axis_z,
  input  logic signed [23:0] turn_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               overflow
);

  localparam int L = CORDIC_STAGES + 9;

  logic                           adv;
  logic [L-1:0]                   vld;
  logic signed [aavr_pkg::CW-1:0] sin_v;
  logic signed [aavr_pkg::CW-1:0] cos_v;
  aavr_pkg::geo_t                 geo;

  // Advance the pipeline unless a result is stuck at the output
  assign adv       = !vld[L-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[L-1];

  // Carry valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  aavr_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk   (clk),
    .adv   (adv),
    .ang   (turn_angle),
    .sin_v (sin_v),
    .cos_v (cos_v)
  );

  aavr_geom #(.CORDIC_STAGES(CORDIC_STAGES)) u_geom (
    .clk    (clk),
    .adv    (adv),
    .vec_x  (vec_x),
    .vec_y  (vec_y),
    .vec_z  (vec_z),
    .axis_x (axis_x),
    .axis_y (axis_y),
    .axis_z (axis_z),
    .geo    (geo)
  );

  aavr_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
    .clk      (clk),
    .adv      (adv),
    .geo      (geo),
    .sin_v    (sin_v),
    .cos_v    (cos_v),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .overflow (overflow)
  );

  // Overflow only accompanies a clamped component
  a_ovf_clamped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |->
      (out_x == 32'sh7FFFFFFF || out_x == 32'sh80000000 ||
       out_y == 32'sh7FFFFFFF || out_y == 32'sh80000000 ||
       out_z == 32'sh7FFFFFFF || out_z == 32'sh80000000))
    else $error("overflow set without a saturated component");

  // Nothing emerges straight after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Input is only held back by a waiting result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled with no waiting result");

endmodule

// ===== rtl/aavr_cordic.sv =====
// Pipelined sine and cosine: angle reduction, one CORDIC stage per register, sign fix.
module aavr_cordic #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic                            clk,
  input  logic                            adv,
  input  logic signed [23:0]              ang,
  output logic signed [aavr_pkg::CW-1:0]  sin_v,
  output logic signed [aavr_pkg::CW-1:0]  cos_v
);

  localparam int N = CORDIC_STAGES;

  logic signed [aavr_pkg::ZW-1:0] z_in;
  logic signed [aavr_pkg::ZW-1:0] z_wrap;
  logic signed [aavr_pkg::ZW-1:0] z_fold;
  logic                           flip_in;

  logic signed [aavr_pkg::CW-1:0] xs [N+1];
  logic signed [aavr_pkg::CW-1:0] ys [N+1];
  logic signed [aavr_pkg::ZW-1:0] zs [N+1];
  logic                           fl [N+1];

  // Widen to Q.30, wrap into -pi..pi, fold into -pi/2..pi/2
  always_comb begin
    z_in = {{2{ang[23]}}, ang, 10'b0};
    if (z_in > aavr_pkg::PI_Q30) begin
      z_wrap = z_in - aavr_pkg::TWO_PI_Q30;
    end else if (z_in < -aavr_pkg::PI_Q30) begin
      z_wrap = z_in + aavr_pkg::TWO_PI_Q30;
    end else begin
      z_wrap = z_in;
    end
    if (z_wrap > aavr_pkg::HALF_PI_Q30) begin
      z_fold  = z_wrap - aavr_pkg::PI_Q30;
      flip_in = 1'b1;
    end else if (z_wrap < -aavr_pkg::HALF_PI_Q30) begin
      z_fold  = z_wrap + aavr_pkg::PI_Q30;
      flip_in = 1'b1;
    end else begin
      z_fold  = z_wrap;
      flip_in = 1'b0;
    end
  end

  // Load the first stage
  always_ff @(posedge clk) begin
    if (adv) begin
      xs[0] <= aavr_pkg::CW'(aavr_pkg::GAIN_Q30);
      ys[0] <= '0;
      zs[0] <= z_fold;
      fl[0] <= flip_in;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        fl[i+1] <= fl[i];
        if (!zs[i][aavr_pkg::ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - aavr_pkg::atan_q30(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + aavr_pkg::atan_q30(i);
        end
      end
    end
  end

  // Undo the fold by negating both results
  always_ff @(posedge clk) begin
    if (adv) begin
      cos_v <= fl[N] ? -xs[N] : xs[N];
      sin_v <= fl[N] ? -ys[N] : ys[N];
    end
  end

endmodule

// ===== rtl/aavr_geom.sv =====
// Dot and cross products of axis and vector, delayed to line up with the CORDIC.
module aavr_geom #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [31:0]   vec_x,
  input  logic signed [31:0]   vec_y,
  input  logic signed [31:0]   vec_z,
  input  logic signed [18:0]   axis_x,
  input  logic signed [18:0]   axis_y,
  input  logic signed [18:0]   axis_z,
  output aavr_pkg::geo_t       geo
);

  localparam int N = CORDIC_STAGES;

  logic signed [31:0] vin [3];
  logic signed [18:0] kin [3];
  logic [2:0][31:0]   v1;
  logic [2:0][18:0]   k1;
  logic signed [50:0] pr [3][3];
  aavr_pkg::geo_t     g2;
  aavr_pkg::geo_t     dl [N];

  assign vin[0] = vec_x;
  assign vin[1] = vec_y;
  assign vin[2] = vec_z;
  assign kin[0] = axis_x;
  assign kin[1] = axis_y;
  assign kin[2] = axis_z;

  // Form all axis-by-vector products
  always_ff @(posedge clk) begin
    if (adv) begin
      v1 <= {vec_z, vec_y, vec_x};
      k1 <= {axis_z, axis_y, axis_x};
      for (int j = 0; j < 3; j++) begin
        for (int m = 0; m < 3; m++) begin
          pr[j][m] <= kin[j] * vin[m];
        end
      end
    end
  end

  // Sum into dot and cross
  always_ff @(posedge clk) begin
    if (adv) begin
      g2.v     <= v1;
      g2.k     <= k1;
      g2.dot   <= 53'(pr[0][0]) + 53'(pr[1][1]) + 53'(pr[2][2]);
      g2.cr[0] <= 52'(pr[1][2]) - 52'(pr[2][1]);
      g2.cr[1] <= 52'(pr[2][0]) - 52'(pr[0][2]);
      g2.cr[2] <= 52'(pr[0][1]) - 52'(pr[1][0]);
    end
  end

  // Hold beside the CORDIC stages
  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0] <= g2;
      for (int i = 1; i < N; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  assign geo = dl[N-1];

endmodule

// ===== rtl/aavr_combine.sv =====
// Rodrigues terms: split products, rounding, summation and saturation to the output register.
module aavr_combine #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           adv,
  input  aavr_pkg::geo_t                 geo,
  input  logic signed [aavr_pkg::CW-1:0] sin_v,
  input  logic signed [aavr_pkg::CW-1:0] cos_v,
  output logic signed [31:0]             out_x,
  output logic signed [31:0]             out_y,
  output logic signed [31:0]             out_z,
  output logic                           overflow
);

  localparam int F  = FRAC_BITS;
  localparam int TW = aavr_pkg::TW;

  logic signed [34:0] t;

  // stage one: partial products
  logic signed [61:0] a_pdl, a_pdh;
  logic signed [65:0] a_vc  [3];
  logic signed [60:0] a_crl [3];
  logic signed [59:0] a_crh [3];
  logic [2:0][18:0]   a_k;
  // stage two: full products
  logic signed [87:0] b_pd;
  logic signed [65:0] b_vc [3];
  logic signed [85:0] b_cr [3];
  logic [2:0][18:0]   b_k;
  // stage three: rounded values
  logic signed [87:0] pd_r;
  logic signed [65:0] vc_r [3];
  logic signed [85:0] cr_r [3];
  logic signed [57:0] c_dt;
  logic signed [TW-1:0] c_t1 [3];
  logic signed [TW-1:0] c_t2 [3];
  logic [2:0][18:0]   c_k;
  // stage four and five: axis times scaled dot
  logic signed [48:0] d_kl [3];
  logic signed [47:0] d_kh [3];
  logic signed [TW-1:0] d_s12 [3];
  logic signed [76:0] e_kd [3];
  logic signed [TW-1:0] e_s12 [3];
  // stage six: third term
  logic signed [76:0] kd_r [3];
  logic signed [TW-1:0] f_t3 [3];
  logic signed [TW-1:0] f_s12 [3];
  // stage seven: sum and clamp
  logic signed [TW:0] sum [3];
  logic signed [31:0] sat [3];
  logic [2:0]         ovf;

  assign t = 35'(aavr_pkg::ONE_Q30) - 35'(cos_v);

  // Split the wide operands into halves for the multipliers
  always_ff @(posedge clk) begin
    if (adv) begin
      a_pdl <= $signed({1'b0, geo.dot[25:0]}) * t;
      a_pdh <= $signed(geo.dot[52:26]) * t;
      a_k   <= geo.k;
      for (int j = 0; j < 3; j++) begin
        a_vc[j]  <= $signed(geo.v[j]) * cos_v;
        a_crl[j] <= $signed({1'b0, geo.cr[j][25:0]}) * sin_v;
        a_crh[j] <= $signed(geo.cr[j][51:26]) * sin_v;
      end
    end
  end

  // Recombine the halves
  always_ff @(posedge clk) begin
    if (adv) begin
      b_pd <= (88'(a_pdh) <<< 26) + 88'(a_pdl);
      b_k  <= a_k;
      for (int j = 0; j < 3; j++) begin
        b_vc[j] <= a_vc[j];
        b_cr[j] <= (86'(a_crh[j]) <<< 26) + 86'(a_crl[j]);
      end
    end
  end

  // Round to nearest, ties away from zero
  always_comb begin
    pd_r = b_pd + (88'sd1 <<< 29) - $signed({87'b0, b_pd[87]});
    for (int j = 0; j < 3; j++) begin
      vc_r[j] = b_vc[j] + (66'sd1 <<< 29) - $signed({65'b0, b_vc[j][65]});
      cr_r[j] = b_cr[j] + (86'sd1 <<< (29 + F)) - $signed({85'b0, b_cr[j][85]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_dt <= 58'(pd_r >>> 30);
      c_k  <= b_k;
      for (int j = 0; j < 3; j++) begin
        c_t1[j] <= TW'(vc_r[j] >>> 30);
        c_t2[j] <= TW'(cr_r[j] >>> (30 + F));
      end
    end
  end

  // Axis times scaled dot, in two halves; add the first two terms
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        d_kl[j]  <= $signed(c_k[j]) * $signed({1'b0, c_dt[28:0]});
        d_kh[j]  <= $signed(c_k[j]) * $signed(c_dt[57:29]);
        d_s12[j] <= c_t1[j] + c_t2[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        e_kd[j]  <= (77'(d_kh[j]) <<< 29) + 77'(d_kl[j]);
        e_s12[j] <= d_s12[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      kd_r[j] = e_kd[j] + (77'sd1 <<< (2 * F - 1)) - $signed({76'b0, e_kd[j][76]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        f_t3[j]  <= TW'(kd_r[j] >>> (2 * F));
        f_s12[j] <= e_s12[j];
      end
    end
  end

  // Sum and clamp to 32 bits
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = (TW+1)'(f_s12[j]) + (TW+1)'(f_t3[j]);
      if (sum[j] > (TW+1)'(64'sd2147483647)) begin
        sat[j] = 32'sh7FFFFFFF;
        ovf[j] = 1'b1;
      end else if (sum[j] < (TW+1)'(-64'sd2147483648)) begin
        sat[j] = 32'sh80000000;
        ovf[j] = 1'b1;
      end else begin
        sat[j] = 32'(sum[j]);
        ovf[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x    <= sat[0];
      out_y    <= sat[1];
      out_z    <= sat[2];
      overflow <= |ovf;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the axis-angle vector rotation pipeline.
module tb_top;

  localparam int NSTAGE  = 20;
  localparam int FRAC    = 16;
  localparam int LATENCY = NSTAGE + 9;
  localparam int N_RAND  = 1200;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic signed [18:0] kx, ky, kz;
    logic signed [23:0] ang;
  } rot_req_t;

  typedef struct {
    logic signed [31:0] rx, ry, rz;
    logic               ovf;
  } rot_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic signed [18:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic signed [23:0] turn_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic overflow;

  rot_req_t pending_q[$];
  rot_res_t rotated_q[$];
  int       n_err = 0;
  bit       stim_done = 1'b0;
  longint   cyc = 0;

  always #4 clk = ~clk;

  axis_angle_vector_rotation #(.CORDIC_STAGES(NSTAGE), .FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .turn_angle(turn_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .overflow(overflow)
  );

  function automatic longint atan_entry(int i);
    longint tab[28] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8};
    return tab[i];
  endfunction

  // Round a*b / 2^sh to nearest, ties away from zero, clamp magnitude to 2^60
  function automatic longint scale_round(longint a, longint b, int sh);
    logic [127:0] ma, mb, p;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? 128'(-a) : 128'(a);
    mb  = (b < 0) ? 128'(-b) : 128'(b);
    p   = ((ma * mb) + (128'd1 << (sh - 1))) >> sh;
    if (p > (128'd1 << 60)) p = 128'd1 << 60;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // Sine and cosine in Q.30, reducing and folding the angle first
  function automatic void sin_cos_q30(input logic signed [23:0] ang,
                                      output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(ang) * 1024;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd3373259426) z -= 64'sd6746518852;
    else if (z < -64'sd3373259426) z += 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < NSTAGE && i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_entry(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_entry(i);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic rot_res_t rodrigues(rot_req_t q);
    rot_res_t r;
    longint v[3], k[3], cr[3], sn, cs, t, dot, dt, s;
    v = '{q.vx, q.vy, q.vz};
    k = '{q.kx, q.ky, q.kz};
    sin_cos_q30(q.ang, sn, cs);
    t = 64'sd1073741824 - cs;
    dot = k[0] * v[0] + k[1] * v[1] + k[2] * v[2];
    cr[0] = k[1] * v[2] - k[2] * v[1];
    cr[1] = k[2] * v[0] - k[0] * v[2];
    cr[2] = k[0] * v[1] - k[1] * v[0];
    dt = scale_round(dot, t, 30);
    r.ovf = 1'b0;
    for (int j = 0; j < 3; j++) begin
      s = scale_round(v[j], cs, 30) + scale_round(cr[j], sn, 30 + FRAC)
        + scale_round(k[j], dt, 2 * FRAC);
      if (s > 64'sd2147483647) begin
        s = 64'sd2147483647;
        r.ovf = 1'b1;
      end else if (s < -64'sd2147483648) begin
        s = -64'sd2147483648;
        r.ovf = 1'b1;
      end
      if (j == 0) r.rx = s[31:0];
      else if (j == 1) r.ry = s[31:0];
      else r.rz = s[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [18:0] rand_axis(int mode);
    case (mode)
      0: return 19'sd65536;
      1: return -19'sd65536;
      2: return 19'sd131072;
      3: return -19'sd131072;
      4: return 19'(int'($urandom_range(0, 262144)) - 131072);
      default: return 19'(int'($urandom_range(0, 92682)) - 46341);
    endcase
  endfunction

  function automatic rot_req_t make_req(int vx, int vy, int vz, int kx, int ky,
                                        int kz, int ang);
    rot_req_t q;
    q.vx = vx; q.vy = vy; q.vz = vz;
    q.kx = 19'(kx); q.ky = 19'(ky); q.kz = 19'(kz);
    q.ang = 24'(ang);
    return q;
  endfunction

  // Fill the stimulus queue: directed corners first, then random items
  initial begin
    rot_req_t q;
    int       vm;
    pending_q.push_back(make_req(0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(65536, 0, 0, 0, 0, 65536, 1647099));
    pending_q.push_back(make_req(65536, 65536, 0, 0, 0, 65536, 3294199));
    // angle exactly at pi and -pi in Q.30 terms is not representable; near them
    pending_q.push_back(make_req(65536, 0, 0, 0, 0, 65536, 3294198));
    pending_q.push_back(make_req(65536, 0, 0, 0, 0, 65536, -3294198));
    pending_q.push_back(make_req(65536, 0, 0, 0, 0, 65536, 3294200));
    pending_q.push_back(make_req(65536, 0, 0, 0, 0, 65536, -3294200));
    pending_q.push_back(make_req(65536, 0, 0, 0, 0, 65536, 8388607));
    pending_q.push_back(make_req(65536, 0, 0, 0, 0, 65536, -8388608));
    pending_q.push_back(make_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                 131072, 131072, 131072, 823549));
    pending_q.push_back(make_req(32'h80000000, 32'h80000000, 32'h80000000,
                                 -131072, -131072, -131072, -823549));
    pending_q.push_back(make_req(32'h7fffffff, 32'h80000000, 0,
                                 -131072, 131072, -131072, 8388607));
    pending_q.push_back(make_req(-1, -1, -1, 65536, 0, 0, 1647100));
    pending_q.push_back(make_req(32'h7fffffff, 0, 0, 0, 0, 65536, 0));
    pending_q.push_back(make_req(32'h12345678, -32'h12345678, 32'h0badcafe,
                                 37837, 37837, 37837, 2000000));
    pending_q.push_back(make_req(100, 200, 300, 65536, 0, 0, -1647099));
    for (int n = 0; n < N_RAND; n++) begin
      vm = $urandom_range(0, 9);
      q.vx = $urandom;
      q.vy = $urandom;
      q.vz = $urandom;
      // mostly modest vectors so saturation stays occasional
      if (vm < 7) begin
        q.vx = q.vx >>> $urandom_range(1, 24);
        q.vy = q.vy >>> $urandom_range(1, 24);
        q.vz = q.vz >>> $urandom_range(1, 24);
      end
      q.kx = rand_axis($urandom_range(0, 5));
      q.ky = rand_axis($urandom_range(0, 5));
      q.kz = rand_axis($urandom_range(0, 5));
      q.ang = 24'($urandom);
      pending_q.push_back(q);
    end
  end

  // Drive transactions in bursts separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == 10) rst <= 1'b0;
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (in_valid) rotated_q.push_back(rodrigues(make_req(vec_x, vec_y, vec_z,
                                         axis_x, axis_y, axis_z, turn_angle)));
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          rot_req_t q;
          q = pending_q.pop_front();
          in_valid   <= 1'b1;
          vec_x      <= q.vx;
          vec_y      <= q.vy;
          vec_z      <= q.vz;
          axis_x     <= q.kx;
          axis_y     <= q.ky;
          axis_z     <= q.kz;
          turn_angle <= q.ang;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid  <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // Receiver: stall on its own pattern, with one long hold-off early on
  int hold_left = 0;
  bit long_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!long_done && cyc > 200) begin
      long_done <= 1'b1;
      hold_left <= 120;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ((cyc / 300) % 3 == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    rot_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (rotated_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d", out_x, out_y, out_z);
        n_err++;
      end else begin
        e = rotated_q.pop_front();
        if (out_x !== e.rx) begin
          $error("out_x expected %0d actual %0d", e.rx, out_x);
          n_err++;
        end
        if (out_y !== e.ry) begin
          $error("out_y expected %0d actual %0d", e.ry, out_y);
          n_err++;
        end
        if (out_z !== e.rz) begin
          $error("out_z expected %0d actual %0d", e.rz, out_z);
          n_err++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow expected %0d actual %0d", e.ovf, overflow);
          n_err++;
        end
      end
    end
  end

  // Drain, settle, then report
  initial begin
    wait (stim_done && rotated_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_err == 0 && rotated_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (cyc > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

// ===== axis_angle_vector_rotation.f =====
rtl/aavr_pkg.sv
rtl/aavr_cordic.sv
rtl/aavr_geom.sv
rtl/aavr_combine.sv
rtl/axis_angle_vector_rotation.sv
tb/tb_top.sv
